// ----- hdl/btop_pkg.sv -----
// Shared constants, types and fixed-point helpers for the binomial tree option pricer.
// Depends on nothing; every other file of the block refers to it by scoped names.

package btop_pkg;

    // Tree size and derived widths.
    localparam int MAX_STEPS  = 256;
    localparam int NODE_DEPTH = MAX_STEPS + 1;
    localparam int IDX_W      = $clog2(NODE_DEPTH);
    localparam int WORD_W     = 32;
    localparam int STEP_W     = 9;
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_UP_FACTOR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_FACTOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_WEIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_WEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT  = 3'd4;

    // Fixed-point constants and register reset values.
    localparam logic [WORD_W-1:0] Q30_ONE  = 32'h4000_0000;
    localparam logic [WORD_W-1:0] Q30_HALF = 32'h2000_0000;
    localparam logic [STEP_W-1:0] STEP_RESET = 9'd1;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [IDX_W-1:0]  idx_t;

    // Product of a Q2.30 multiply with its saturation flag.
    typedef struct packed {
        logic  sat;
        word_t val;
    } prod_t;

    // One pricing request as held by the engine.
    typedef struct packed {
        word_t spot;
        word_t strike;
        logic  is_call;
    } job_t;

    // Tree parameters taken from the configuration registers.
    typedef struct packed {
        word_t up_factor;
        word_t down_factor;
        word_t up_weight;
        word_t down_weight;
        idx_t  steps;
    } params_t;

    // Control from the top level into the engine.
    typedef struct packed {
        logic start;
        logic res_ready;
    } eng_ctl_t;

    // Status and result from the engine.
    typedef struct packed {
        logic  idle;
        logic  done;
        word_t price;
        logic  sat;
    } eng_sts_t;

    // Engine sequencer states.
    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_LEAF,
        ENG_SCALE,
        ENG_SWEEP,
        ENG_DRAIN,
        ENG_READOUT,
        ENG_RESULT
    } eng_state_t;

    // Truncating Q2.30 multiply; results above the word saturate.
    function automatic prod_t mul_q30(word_t a, word_t b);
        logic [2*WORD_W-1:0] p;
        prod_t r;
        p = {{WORD_W{1'b0}}, a} * {{WORD_W{1'b0}}, b};
        r.sat = |p[2*WORD_W-1:2*WORD_W-2];
        r.val = r.sat ? '1 : p[2*WORD_W-3:WORD_W-2];
        return r;
    endfunction

endpackage

// ----- hdl/btop_if.sv -----
// Handshake channel interfaces for the option pricer: request, result and configuration.
// Depends on btop_pkg for the word type and widths.

interface btop_req_if;
    logic                 valid;
    logic                 ready;
    btop_pkg::word_t      spot_price;
    btop_pkg::word_t      strike_price;
    logic                 is_call;

    modport source (output valid, spot_price, strike_price, is_call, input ready);
    modport sink   (input valid, spot_price, strike_price, is_call, output ready);
endinterface

interface btop_rsp_if;
    logic                 valid;
    logic                 ready;
    btop_pkg::word_t      option_price;
    logic                 saturated;

    modport source (output valid, option_price, saturated, input ready);
    modport sink   (input valid, option_price, saturated, output ready);
endinterface

interface btop_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [btop_pkg::CFG_IDX_W-1:0]    index;
    btop_pkg::word_t                   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/btop_engine.sv -----
// Pricing engine: node memory, leaf build, payoff pass and backward sweep sequencer.
// Depends on btop_pkg for types, the state enum and the Q2.30 multiply.

module btop_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  btop_pkg::eng_ctl_t ctl,
    input  btop_pkg::job_t     job,
    input  btop_pkg::params_t  params,
    output btop_pkg::eng_sts_t sts
);

    // Node memory, one write and one registered read port.
    btop_pkg::word_t node_mem [btop_pkg::NODE_DEPTH];
    btop_pkg::word_t rd_data_reg;
    logic            rd_en;
    btop_pkg::idx_t  rd_addr;
    logic            wr_en;
    btop_pkg::idx_t  wr_addr;
    btop_pkg::word_t wr_data;

    // Sequencer state.
    btop_pkg::eng_state_t state_reg, state_next;
    btop_pkg::idx_t       k_reg, k_next;
    btop_pkg::idx_t       lvl_reg, lvl_next;
    btop_pkg::word_t      price_reg, price_next;
    btop_pkg::word_t      dpow_reg, dpow_next;
    btop_pkg::word_t      hold_reg, hold_next;
    logic                 sat_reg, sat_next;
    btop_pkg::word_t      strike_reg;
    logic                 call_reg;

    // Pipeline: stage one sees read data, stage two writes back.
    logic            s1_rd_reg, s1_item_reg, s1_scale_reg;
    btop_pkg::idx_t  s1_wa_reg;
    logic            s2_item_reg, s2_scale_reg;
    btop_pkg::idx_t  s2_wa_reg;
    btop_pkg::word_t s2_a_reg, s2_b_reg;

    logic            issue_item;
    logic            issue_scale;
    btop_pkg::idx_t  issue_wa;

    btop_pkg::prod_t mul_a, mul_b, mul_c;
    btop_pkg::word_t mul_a_x, mul_a_y, mul_c_x, mul_c_y;
    logic [btop_pkg::WORD_W:0] sum;
    btop_pkg::word_t payoff;

    // Memory access.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            node_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= node_mem[rd_addr];
        end
    end

    // Shared multipliers: node products and the running price or down power.
    always_comb
    begin
        mul_a_x = s1_scale_reg ? rd_data_reg : params.up_weight;
        mul_a_y = s1_scale_reg ? dpow_reg : hold_reg;
        mul_c_x = (state_reg == btop_pkg::ENG_LEAF) ? price_reg : dpow_reg;
        mul_c_y = (state_reg == btop_pkg::ENG_LEAF) ? params.up_factor : params.down_factor;
        mul_a   = btop_pkg::mul_q30(mul_a_x, mul_a_y);
        mul_b   = btop_pkg::mul_q30(params.down_weight, rd_data_reg);
        mul_c   = btop_pkg::mul_q30(mul_c_x, mul_c_y);
    end

    // Write-back values: payoff for the leaf pass, saturating sum for the sweep.
    always_comb
    begin
        sum = {1'b0, s2_a_reg} + {1'b0, s2_b_reg};
        if (call_reg)
        begin
            payoff = (s2_a_reg > strike_reg) ? (s2_a_reg - strike_reg) : '0;
        end
        else
        begin
            payoff = (strike_reg > s2_a_reg) ? (strike_reg - s2_a_reg) : '0;
        end
    end

    // Sequencer next state, memory control and pipeline updates.
    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        lvl_next    = lvl_reg;
        price_next  = price_reg;
        dpow_next   = dpow_reg;
        hold_next   = hold_reg;
        sat_next    = sat_reg;
        rd_en       = 1'b0;
        rd_addr     = k_reg;
        wr_en       = 1'b0;
        wr_addr     = s2_wa_reg;
        wr_data     = s2_scale_reg ? payoff :
                      (sum[btop_pkg::WORD_W] ? '1 : sum[btop_pkg::WORD_W-1:0]);
        issue_item  = 1'b0;
        issue_scale = 1'b0;
        issue_wa    = k_reg;
        sts.idle    = 1'b0;
        sts.done    = 1'b0;
        sts.price   = rd_data_reg;
        sts.sat     = sat_reg;

        unique case (state_reg)
            btop_pkg::ENG_IDLE:
            begin
                sts.idle = 1'b1;
                if (ctl.start)
                begin
                    price_next = job.spot;
                    dpow_next  = btop_pkg::Q30_ONE;
                    sat_next   = 1'b0;
                    k_next     = '0;
                    lvl_next   = params.steps;
                    state_next = btop_pkg::ENG_LEAF;
                end
            end
            btop_pkg::ENG_LEAF:
            begin
                // Leaf n-k takes spot * up^k.
                wr_en   = 1'b1;
                wr_addr = lvl_reg - k_reg;
                wr_data = price_reg;
                if (k_reg != lvl_reg)
                begin
                    price_next = mul_c.val;
                    sat_next   = sat_reg | mul_c.sat;
                    k_next     = k_reg + 1'b1;
                end
                else
                begin
                    k_next     = '0;
                    state_next = btop_pkg::ENG_SCALE;
                end
            end
            btop_pkg::ENG_SCALE:
            begin
                rd_en       = 1'b1;
                issue_item  = 1'b1;
                issue_scale = 1'b1;
                issue_wa    = k_reg;
                if (k_reg == lvl_reg)
                begin
                    state_next = btop_pkg::ENG_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            btop_pkg::ENG_SWEEP:
            begin
                // The first read of a level only primes the held left node.
                rd_en      = 1'b1;
                issue_item = (k_reg != '0);
                issue_wa   = k_reg - 1'b1;
                if (k_reg == lvl_reg)
                begin
                    lvl_next   = lvl_reg - 1'b1;
                    state_next = btop_pkg::ENG_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            btop_pkg::ENG_DRAIN:
            begin
                // Wait for all write-backs before the next level reads.
                if (!s1_rd_reg && !s2_item_reg)
                begin
                    k_next     = '0;
                    state_next = (lvl_reg == '0) ? btop_pkg::ENG_READOUT : btop_pkg::ENG_SWEEP;
                end
            end
            btop_pkg::ENG_READOUT:
            begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = btop_pkg::ENG_RESULT;
            end
            btop_pkg::ENG_RESULT:
            begin
                sts.done = 1'b1;
                if (ctl.res_ready)
                begin
                    state_next = btop_pkg::ENG_IDLE;
                end
            end
            default:
            begin
                state_next = btop_pkg::ENG_IDLE;
            end
        endcase

        // Stage one: products, down power advance and left node hand-over.
        if (s1_rd_reg)
        begin
            hold_next = rd_data_reg;
        end
        if (s1_item_reg)
        begin
            if (s1_scale_reg)
            begin
                sat_next = sat_next | mul_a.sat;
                if (s1_wa_reg != lvl_reg)
                begin
                    dpow_next = mul_c.val;
                    sat_next  = sat_next | mul_c.sat;
                end
            end
            else
            begin
                sat_next = sat_next | mul_a.sat | mul_b.sat;
            end
        end

        // Stage two: write back.
        if (s2_item_reg)
        begin
            wr_en = 1'b1;
            if (!s2_scale_reg)
            begin
                sat_next = sat_next | sum[btop_pkg::WORD_W];
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= btop_pkg::ENG_IDLE;
            k_reg        <= '0;
            lvl_reg      <= '0;
            sat_reg      <= 1'b0;
            s1_rd_reg    <= 1'b0;
            s1_item_reg  <= 1'b0;
            s1_scale_reg <= 1'b0;
            s2_item_reg  <= 1'b0;
            s2_scale_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            lvl_reg      <= lvl_next;
            sat_reg      <= sat_next;
            s1_rd_reg    <= rd_en;
            s1_item_reg  <= issue_item;
            s1_scale_reg <= issue_scale;
            s2_item_reg  <= s1_item_reg;
            s2_scale_reg <= s1_scale_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        price_reg <= price_next;
        dpow_reg  <= dpow_next;
        hold_reg  <= hold_next;
        s1_wa_reg <= issue_wa;
        s2_wa_reg <= s1_wa_reg;
        s2_a_reg  <= mul_a.val;
        s2_b_reg  <= s1_scale_reg ? '0 : mul_b.val;
        if (ctl.start && (state_reg == btop_pkg::ENG_IDLE))
        begin
            strike_reg <= job.strike;
            call_reg   <= job.is_call;
        end
    end

endmodule

// ----- hdl/binomial_tree_option_pricer.sv -----
// Top level of the binomial tree option pricer: configuration registers, request
// intake and result register around btop_engine. Depends on btop_pkg and btop_if.
//
// Usage. Software writes up_factor, down_factor, up_weight, down_weight (Q2.30) and
// step_count through the cfg channel while the block is idle; cfg is always ready.
// A step_count above the built maximum of 256 is taken as 256. Each req transaction
// carries spot, strike (Q16.16) and the call or put choice; each one gives exactly
// one rsp transaction with the root value and the saturation flag for that run.
// The node memory's single read port sets the time a run takes: the backward sweep
// updates one node per cycle and drains its three-stage read, multiply, write-back
// pipeline at the end of every level. One request is priced at a time; req is ready
// whenever the engine is idle, even while a result waits in the rsp register.
// If the receiver stalls with a result waiting, a finished run holds in the engine
// until the register frees. Reset restores the configuration reset values and
// empties the result register; node memory contents are not cleared.

module binomial_tree_option_pricer (
    input  logic              clk,
    input  logic              rst_n,
    btop_cfg_if.sink          cfg,
    btop_req_if.sink          req,
    btop_rsp_if.source        rsp
);

    localparam int CMP_W = (btop_pkg::IDX_W > btop_pkg::STEP_W) ?
                           btop_pkg::IDX_W : btop_pkg::STEP_W;

    btop_pkg::word_t                 up_factor_reg;
    btop_pkg::word_t                 down_factor_reg;
    btop_pkg::word_t                 up_weight_reg;
    btop_pkg::word_t                 down_weight_reg;
    logic [btop_pkg::STEP_W-1:0]     step_count_reg;
    logic [CMP_W-1:0]                steps_ext;

    logic                            rsp_valid_reg;
    btop_pkg::word_t                 rsp_price_reg;
    logic                            rsp_sat_reg;

    btop_pkg::eng_ctl_t              eng_ctl;
    btop_pkg::eng_sts_t              eng_sts;
    btop_pkg::job_t                  job;
    btop_pkg::params_t               params;

    // Configuration writes.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_factor_reg   <= btop_pkg::Q30_ONE;
            down_factor_reg <= btop_pkg::Q30_ONE;
            up_weight_reg   <= btop_pkg::Q30_HALF;
            down_weight_reg <= btop_pkg::Q30_HALF;
            step_count_reg  <= btop_pkg::STEP_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                btop_pkg::CFG_UP_FACTOR:   up_factor_reg   <= cfg.data;
                btop_pkg::CFG_DOWN_FACTOR: down_factor_reg <= cfg.data;
                btop_pkg::CFG_UP_WEIGHT:   up_weight_reg   <= cfg.data;
                btop_pkg::CFG_DOWN_WEIGHT: down_weight_reg <= cfg.data;
                btop_pkg::CFG_STEP_COUNT:  step_count_reg  <= cfg.data[btop_pkg::STEP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Tree parameters, with the step count limited to the built maximum.
    always_comb
    begin
        steps_ext          = CMP_W'(step_count_reg);
        params.up_factor   = up_factor_reg;
        params.down_factor = down_factor_reg;
        params.up_weight   = up_weight_reg;
        params.down_weight = down_weight_reg;
        if (steps_ext > CMP_W'(btop_pkg::MAX_STEPS))
        begin
            params.steps = btop_pkg::IDX_W'(btop_pkg::MAX_STEPS);
        end
        else
        begin
            params.steps = steps_ext[btop_pkg::IDX_W-1:0];
        end
    end

    // Request intake and engine control.
    assign req.ready         = eng_sts.idle;
    assign job.spot          = req.spot_price;
    assign job.strike        = req.strike_price;
    assign job.is_call       = req.is_call;
    assign eng_ctl.start     = req.valid && eng_sts.idle;
    assign eng_ctl.res_ready = !rsp_valid_reg || rsp.ready;

    btop_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (eng_ctl),
        .job    (job),
        .params (params),
        .sts    (eng_sts)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (eng_sts.done && eng_ctl.res_ready)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_sts.done && eng_ctl.res_ready)
        begin
            rsp_price_reg <= eng_sts.price;
            rsp_sat_reg   <= eng_sts.sat;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.option_price = rsp_price_reg;
    assign rsp.saturated    = rsp_sat_reg;

    // An accepted request makes the engine busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("engine still idle after a request transaction");

    // Ready only drops because a request was taken.
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(req.ready) |-> $past(req.valid))
        else $error("request ready fell without a transaction");

    // A new result only appears from a run that was in progress.
    a_rsp_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> !$past(req.ready))
        else $error("result appeared while the engine was idle");

    // A finished run holds its value while the result register is occupied.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (eng_sts.done && !eng_ctl.res_ready) |=> (eng_sts.done && $stable(eng_sts.price)))
        else $error("engine result lost while the result register was full");

endmodule
